// ----- hdl/pmftl_pkg.sv -----
// ----------------------------------------------------------------------------
// pmftl_pkg
// Shared sizes, codes and types of the page-mapping translation layer.
// ----------------------------------------------------------------------------
package pmftl_pkg;

	// geometry
	localparam int BLOCK_COUNT       = 64;
	localparam int BLOCK_SECTORS     = 8;
	localparam int PHYS_SECTORS      = BLOCK_COUNT * BLOCK_SECTORS;
	localparam int LOGICAL_SPACE     = 512;
	localparam int BLK_W             = $clog2(BLOCK_COUNT);
	localparam int SEC_W             = $clog2(BLOCK_SECTORS);
	localparam int PS_W              = BLK_W + SEC_W;
	localparam int LS_W              = $clog2(LOGICAL_SPACE);
	localparam int CNT_W             = $clog2(BLOCK_SECTORS + 1);
	localparam int FREE_W            = $clog2(BLOCK_COUNT + 1);
	localparam int SCAN_W            = BLK_W + 1;
	localparam int ERASE_W           = 32;
	localparam int MAX_RESULTS       = 64;
	localparam int N_W               = $clog2(MAX_RESULTS);

	// configuration port
	localparam int CFG_IDX_W  = 2;
	localparam int CFG_DATA_W = 10;
	localparam int THR_W      = 7;
	localparam int LSEC_W     = 10;

	localparam logic [CFG_IDX_W-1:0] CFG_WEAR_MODE = 2'd0;
	localparam logic [CFG_IDX_W-1:0] CFG_GC_THR    = 2'd1;
	localparam logic [CFG_IDX_W-1:0] CFG_GC_EXTRA  = 2'd2;
	localparam logic [CFG_IDX_W-1:0] CFG_LOG_SECS  = 2'd3;

	localparam logic              RST_WEAR_MODE = 1'b1;
	localparam logic [THR_W-1:0]  RST_GC_THR    = 7'd2;
	localparam logic [THR_W-1:0]  RST_GC_EXTRA  = 7'd1;
	localparam logic [LSEC_W-1:0] RST_LOG_SECS  = 10'd448;

	// request kinds
	localparam logic KIND_READ  = 1'b0;
	localparam logic KIND_WRITE = 1'b1;

	// result kinds
	localparam logic [1:0] RK_XLATE = 2'd0;
	localparam logic [1:0] RK_COPY  = 2'd1;
	localparam logic [1:0] RK_ERASE = 2'd2;

	// status codes
	localparam logic [2:0] ST_OK        = 3'd0;
	localparam logic [2:0] ST_RANGE     = 3'd1;
	localparam logic [2:0] ST_NO_FREE   = 3'd2;
	localparam logic [2:0] ST_NO_VICTIM = 3'd3;
	localparam logic [2:0] ST_GC_LIMIT  = 3'd4;

	typedef struct packed {
		logic            valid;
		logic [PS_W-1:0] ps;
	} fwd_entry_t;

	typedef struct packed {
		logic                     free;
		logic [ERASE_W-1:0]       erase;
		logic [BLOCK_SECTORS-1:0] inv;
	} blk_entry_t;

	typedef struct packed {
		logic [1:0]       result_kind;
		logic [PS_W-1:0]  physical_sector;
		logic [PS_W-1:0]  source_sector;
		logic [BLK_W-1:0] erase_block_index;
		logic             mapped;
		logic [2:0]       status;
		logic             last;
	} res_t;

	// datapath operations
	typedef enum logic [4:0] {
		OP_NONE,
		OP_CLEAR,
		OP_ACCEPT,
		OP_EMIT_RANGE,
		OP_EMIT_READ,
		OP_EMIT_FAIL,
		OP_SCAN_START,
		OP_SCAN_STEP,
		OP_GC_STOP,
		OP_VICTIM_READ,
		OP_VICTIM_LOAD,
		OP_CP_SKIP,
		OP_CP_REV_READ,
		OP_CP_FWD_READ,
		OP_ALLOC_COPY,
		OP_WP_INC,
		OP_TAKE_BLOCK,
		OP_DST_READ,
		OP_CP_EMIT,
		OP_ERASE,
		OP_OLD_READ,
		OP_OLD_INV,
		OP_WR_EMIT
	} op_t;

	typedef struct packed {
		op_t        op;
		logic [2:0] reason;
		logic       victim_scan;
	} cmd_t;

	typedef struct packed {
		logic clear_done;
		logic in_range_err;
		logic in_write;
		logic slot_free;
		logic full_trig;
		logic gc_done;
		logic n_limit;
		logic scan_done;
		logic found;
		logic best_zero;
		logic i_done;
		logic cur_inv;
		logic map_ok;
		logic need_block;
		logic free_zero;
		logic ctx_copy;
		logic fwd_valid;
	} status_t;

endpackage

// ----- hdl/pmftl_req_if.sv -----
// ----------------------------------------------------------------------------
// pmftl_req_if
// Request channel: read or write of one logical sector.
// ----------------------------------------------------------------------------
interface pmftl_req_if import pmftl_pkg::*; ();
	logic            valid;
	logic            ready;
	logic            kind;
	logic [LS_W-1:0] logical_sector;

	modport source (output valid, output kind, output logical_sector, input ready);
	modport sink (input valid, input kind, input logical_sector, output ready);
endinterface

// ----- hdl/pmftl_res_if.sv -----
// ----------------------------------------------------------------------------
// pmftl_res_if
// Result channel: translations, copy commands and erase commands.
// ----------------------------------------------------------------------------
interface pmftl_res_if import pmftl_pkg::*; ();
	logic             valid;
	logic             ready;
	logic [1:0]       result_kind;
	logic [PS_W-1:0]  physical_sector;
	logic [PS_W-1:0]  source_sector;
	logic [BLK_W-1:0] erase_block_index;
	logic             mapped;
	logic [2:0]       status;
	logic             last;

	modport source (output valid, output result_kind, output physical_sector,
		output source_sector, output erase_block_index, output mapped,
		output status, output last, input ready);
	modport sink (input valid, input result_kind, input physical_sector,
		input source_sector, input erase_block_index, input mapped,
		input status, input last, output ready);
endinterface

// ----- hdl/pmftl_dp.sv -----
// ----------------------------------------------------------------------------
// pmftl_dp
// Datapath: mapping memories, block table, allocation and scan registers,
// configuration registers and the result register.
// ----------------------------------------------------------------------------
module pmftl_dp import pmftl_pkg::*; (
	input  logic                  clk,
	input  logic                  arst_n,
	input  cmd_t                  cmd,
	output status_t               st,
	input  logic                  req_kind,
	input  logic [LS_W-1:0]       req_lsn,
	input  logic                  cfg_we,
	input  logic [CFG_IDX_W-1:0]  cfg_index,
	input  logic [CFG_DATA_W-1:0] cfg_data,
	input  logic                  res_ready,
	output logic                  res_valid,
	output res_t                  res_d
);

	// memories
	fwd_entry_t      fwd_mem [LOGICAL_SPACE];
	logic [LS_W-1:0] rev_mem [PHYS_SECTORS];
	blk_entry_t      blk_mem [BLOCK_COUNT];

	// configuration
	logic              mode_q;
	logic [THR_W-1:0]  thr_q;
	logic [THR_W-1:0]  extra_q;
	logic [LSEC_W-1:0] lsecs_q;

	// request and allocation state
	logic [LS_W-1:0]   lsn_q;
	logic [N_W-1:0]    n_q;
	logic [2:0]        reason_q;
	logic              ctx_copy_q;
	logic [PS_W-1:0]   wp_q;
	logic              wp_valid_q;
	logic [FREE_W-1:0] free_total_q;
	logic [LS_W-1:0]   clr_q;

	// scan state
	logic [SCAN_W-1:0]  sc_q;
	logic               rd_vld_q;
	logic [BLK_W-1:0]   rd_idx_q;
	logic               scan_victim_q;
	logic               found_q;
	logic [BLK_W-1:0]   best_q;
	logic [CNT_W-1:0]   best_cnt_q;
	logic [ERASE_W-1:0] best_erase_q;

	// victim state
	logic [BLK_W-1:0]         v_q;
	logic [BLOCK_SECTORS-1:0] vbits_q;
	logic [ERASE_W-1:0]       verase_q;
	logic [SEC_W:0]           i_q;
	logic [LS_W-1:0]          cp_lsn_q;
	logic [PS_W-1:0]          old_q;

	// registered read data
	fwd_entry_t      fwd_rd_q;
	logic [LS_W-1:0] rev_rd_q;
	blk_entry_t      blk_rd_q;

	// memory port controls
	logic            fwd_we, fwd_re, rev_we, rev_re, blk_we, blk_re;
	logic [LS_W-1:0] fwd_waddr, fwd_raddr, rev_wdata;
	fwd_entry_t      fwd_wdata;
	logic [PS_W-1:0] rev_waddr, rev_raddr;
	logic [BLK_W-1:0] blk_waddr, blk_raddr;
	blk_entry_t      blk_wdata;

	logic                     wp_full, skip_open, take, take_v, take_f, emit;
	logic [PS_W-1:0]          src;
	logic [CNT_W-1:0]         inv_cnt;
	logic [THR_W:0]           target;
	logic [BLOCK_SECTORS-1:0] i_mask, old_mask;
	res_t                     res_nxt;

	assign wp_full   = wp_valid_q && (wp_q[SEC_W-1:0] == SEC_W'(BLOCK_SECTORS - 1));
	assign skip_open = wp_valid_q && !wp_full;
	assign src       = {v_q, i_q[SEC_W-1:0]};
	assign i_mask    = BLOCK_SECTORS'(1) << i_q[SEC_W-1:0];
	assign old_mask  = BLOCK_SECTORS'(1) << old_q[SEC_W-1:0];
	assign target    = {1'b0, thr_q} + {1'b0, extra_q};
	assign inv_cnt   = CNT_W'($countones(blk_rd_q.inv));

	// scan candidate selection
	assign take_v = !(skip_open && rd_idx_q == wp_q[PS_W-1:SEC_W]) &&
		(!found_q || inv_cnt > best_cnt_q);
	assign take_f = blk_rd_q.free &&
		(!found_q || (mode_q && blk_rd_q.erase < best_erase_q));
	assign take   = scan_victim_q ? take_v : take_f;

	// status to controller
	always_comb begin
		st.clear_done   = &clr_q;
		st.in_range_err = {1'b0, req_lsn} >= lsecs_q;
		st.in_write     = (req_kind == KIND_WRITE);
		st.slot_free    = !res_valid || res_ready;
		st.full_trig    = wp_full && (free_total_q < thr_q);
		st.gc_done      = {1'b0, free_total_q} >= target;
		st.n_limit      = &n_q;
		st.scan_done    = sc_q[BLK_W] && !rd_vld_q;
		st.found        = found_q;
		st.best_zero    = (best_cnt_q == '0);
		st.i_done       = i_q[SEC_W];
		st.cur_inv      = vbits_q[i_q[SEC_W-1:0]];
		st.map_ok       = fwd_rd_q.valid && (fwd_rd_q.ps == src);
		st.need_block   = !wp_valid_q || wp_full;
		st.free_zero    = (free_total_q == '0);
		st.ctx_copy     = ctx_copy_q;
		st.fwd_valid    = fwd_rd_q.valid;
	end

	// memory port selection
	always_comb begin
		fwd_we    = 1'b0;
		fwd_re    = 1'b0;
		fwd_waddr = lsn_q;
		fwd_raddr = lsn_q;
		fwd_wdata = '{valid: 1'b1, ps: wp_q};
		rev_we    = 1'b0;
		rev_re    = 1'b0;
		rev_waddr = wp_q;
		rev_raddr = src;
		rev_wdata = lsn_q;
		blk_we    = 1'b0;
		blk_re    = 1'b0;
		blk_waddr = v_q;
		blk_raddr = best_q;
		blk_wdata = '{free: 1'b0, erase: verase_q, inv: vbits_q | i_mask};
		unique case (cmd.op)
			OP_CLEAR: begin
				fwd_we    = 1'b1;
				fwd_waddr = clr_q;
				fwd_wdata = '0;
				blk_we    = 1'b1;
				blk_waddr = clr_q[BLK_W-1:0];
				blk_wdata = '{free: 1'b1, erase: '0, inv: '0};
			end
			OP_ACCEPT: begin
				fwd_re    = 1'b1;
				fwd_raddr = req_lsn;
			end
			OP_SCAN_STEP: begin
				blk_re    = !sc_q[BLK_W];
				blk_raddr = sc_q[BLK_W-1:0];
			end
			OP_VICTIM_READ: blk_re = 1'b1;
			OP_CP_REV_READ: rev_re = 1'b1;
			OP_CP_FWD_READ: begin
				fwd_re    = 1'b1;
				fwd_raddr = rev_rd_q;
			end
			OP_TAKE_BLOCK: begin
				blk_we    = 1'b1;
				blk_waddr = best_q;
				blk_wdata = '{free: 1'b0, erase: best_erase_q, inv: '0};
			end
			OP_DST_READ: fwd_re = 1'b1;
			OP_CP_EMIT: begin
				fwd_we    = 1'b1;
				fwd_waddr = cp_lsn_q;
				rev_we    = 1'b1;
				rev_wdata = cp_lsn_q;
				blk_we    = 1'b1;
			end
			OP_ERASE: begin
				blk_we    = 1'b1;
				blk_wdata = '{free: 1'b1, erase: verase_q + 1'b1, inv: '0};
			end
			OP_OLD_READ: begin
				blk_re    = 1'b1;
				blk_raddr = fwd_rd_q.ps[PS_W-1:SEC_W];
			end
			OP_OLD_INV: begin
				blk_we    = 1'b1;
				blk_waddr = old_q[PS_W-1:SEC_W];
				blk_wdata = '{free: blk_rd_q.free, erase: blk_rd_q.erase,
					inv: blk_rd_q.inv | old_mask};
			end
			OP_WR_EMIT: begin
				fwd_we = 1'b1;
				rev_we = 1'b1;
			end
			default: ;
		endcase
	end

	// forward map
	always_ff @(posedge clk) begin
		if (fwd_we) fwd_mem[fwd_waddr] <= fwd_wdata;
		if (fwd_re) fwd_rd_q <= fwd_mem[fwd_raddr];
	end

	// reverse map
	always_ff @(posedge clk) begin
		if (rev_we) rev_mem[rev_waddr] <= rev_wdata;
		if (rev_re) rev_rd_q <= rev_mem[rev_raddr];
	end

	// block table
	always_ff @(posedge clk) begin
		if (blk_we) blk_mem[blk_waddr] <= blk_wdata;
		if (blk_re) blk_rd_q <= blk_mem[blk_raddr];
	end

	// result selection
	always_comb begin
		emit    = 1'b1;
		res_nxt = '{result_kind: RK_XLATE, physical_sector: '0, source_sector: '0,
			erase_block_index: '0, mapped: 1'b0, status: ST_OK, last: 1'b1};
		unique case (cmd.op)
			OP_EMIT_RANGE: res_nxt.status = ST_RANGE;
			OP_EMIT_READ: begin
				res_nxt.mapped = fwd_rd_q.valid;
				if (fwd_rd_q.valid) res_nxt.physical_sector = fwd_rd_q.ps;
			end
			OP_EMIT_FAIL: res_nxt.status = ST_NO_FREE;
			OP_CP_EMIT: begin
				res_nxt.result_kind     = RK_COPY;
				res_nxt.physical_sector = wp_q;
				res_nxt.source_sector   = src;
				res_nxt.last            = 1'b0;
			end
			OP_ERASE: begin
				res_nxt.result_kind       = RK_ERASE;
				res_nxt.erase_block_index = v_q;
				res_nxt.last              = 1'b0;
			end
			OP_WR_EMIT: begin
				res_nxt.physical_sector = wp_q;
				res_nxt.mapped          = 1'b1;
				res_nxt.status          = reason_q;
			end
			default: emit = 1'b0;
		endcase
	end

	// control registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			mode_q       <= RST_WEAR_MODE;
			thr_q        <= RST_GC_THR;
			extra_q      <= RST_GC_EXTRA;
			lsecs_q      <= RST_LOG_SECS;
			wp_valid_q   <= 1'b0;
			free_total_q <= FREE_W'(BLOCK_COUNT);
			clr_q        <= '0;
			res_valid    <= 1'b0;
		end else begin
			if (cfg_we) begin
				unique case (cfg_index)
					CFG_WEAR_MODE: mode_q  <= cfg_data[0];
					CFG_GC_THR:    thr_q   <= cfg_data[THR_W-1:0];
					CFG_GC_EXTRA:  extra_q <= cfg_data[THR_W-1:0];
					CFG_LOG_SECS:  lsecs_q <= cfg_data[LSEC_W-1:0];
					default: ;
				endcase
			end
			if (cmd.op == OP_CLEAR) clr_q <= clr_q + 1'b1;
			if (cmd.op == OP_TAKE_BLOCK) begin
				wp_valid_q <= 1'b1;
				if (free_total_q != '0) free_total_q <= free_total_q - 1'b1;
			end
			if (cmd.op == OP_ERASE) free_total_q <= free_total_q + 1'b1;
			if (emit) res_valid <= 1'b1;
			else if (res_ready) res_valid <= 1'b0;
		end
	end

	// working registers
	always_ff @(posedge clk) begin
		if (emit) res_d <= res_nxt;
		unique case (cmd.op)
			OP_ACCEPT: begin
				lsn_q      <= req_lsn;
				n_q        <= '0;
				reason_q   <= ST_OK;
				ctx_copy_q <= 1'b0;
			end
			OP_SCAN_START: begin
				sc_q          <= '0;
				rd_vld_q      <= 1'b0;
				found_q       <= 1'b0;
				best_cnt_q    <= '0;
				scan_victim_q <= cmd.victim_scan;
			end
			OP_SCAN_STEP: begin
				rd_vld_q <= !sc_q[BLK_W];
				rd_idx_q <= sc_q[BLK_W-1:0];
				if (!sc_q[BLK_W]) sc_q <= sc_q + 1'b1;
				if (rd_vld_q && take) begin
					found_q      <= 1'b1;
					best_q       <= rd_idx_q;
					best_cnt_q   <= inv_cnt;
					best_erase_q <= blk_rd_q.erase;
				end
			end
			OP_GC_STOP: begin
				reason_q   <= cmd.reason;
				ctx_copy_q <= 1'b0;
			end
			OP_VICTIM_READ: v_q <= best_q;
			OP_VICTIM_LOAD: begin
				vbits_q  <= blk_rd_q.inv;
				verase_q <= blk_rd_q.erase;
				i_q      <= '0;
			end
			OP_CP_SKIP: i_q <= i_q + 1'b1;
			OP_CP_FWD_READ: cp_lsn_q <= rev_rd_q;
			OP_ALLOC_COPY: ctx_copy_q <= 1'b1;
			OP_WP_INC: wp_q <= wp_q + 1'b1;
			OP_TAKE_BLOCK: wp_q <= {best_q, SEC_W'(0)};
			OP_CP_EMIT: begin
				vbits_q <= vbits_q | i_mask;
				i_q     <= i_q + 1'b1;
				n_q     <= n_q + 1'b1;
			end
			OP_ERASE: n_q <= n_q + 1'b1;
			OP_OLD_READ: old_q <= fwd_rd_q.ps;
			default: ;
		endcase
	end

	// free block total never exceeds the block count
	a_free_bound: assert property (@(posedge clk) disable iff (!arst_n)
		free_total_q <= FREE_W'(BLOCK_COUNT))
		else $error("free block total above block count");

	// a block is only opened while the free total says one exists
	a_take_free: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.op == OP_TAKE_BLOCK |-> free_total_q != '0)
		else $error("block taken with zero free total");

	// a copy never lands in the block being collected
	a_copy_dst: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.op == OP_CP_EMIT |-> wp_valid_q && wp_q[PS_W-1:SEC_W] != v_q)
		else $error("copy destination inside victim block");

endmodule

// ----- hdl/pmftl_ctrl.sv -----
// ----------------------------------------------------------------------------
// pmftl_ctrl
// Controller: sequences request handling, collection and allocation.
// ----------------------------------------------------------------------------
module pmftl_ctrl import pmftl_pkg::*; (
	input  logic    clk,
	input  logic    arst_n,
	input  logic    req_valid,
	output logic    req_ready,
	input  status_t st,
	output cmd_t    cmd
);

	typedef enum logic [21:0] {
		S_CLEAR    = 22'h000001,
		S_IDLE     = 22'h000002,
		S_RANGE    = 22'h000004,
		S_RD_EMIT  = 22'h000008,
		S_WR_START = 22'h000010,
		S_GC_CHECK = 22'h000020,
		S_VS       = 22'h000040,
		S_VS_END   = 22'h000080,
		S_V_LOAD   = 22'h000100,
		S_CP_TEST  = 22'h000200,
		S_CP_REV   = 22'h000400,
		S_CP_FWD   = 22'h000800,
		S_AL_START = 22'h001000,
		S_FS       = 22'h002000,
		S_FS_END   = 22'h004000,
		S_AL_DONE  = 22'h008000,
		S_CP_EMIT  = 22'h010000,
		S_ER       = 22'h020000,
		S_WR_FWD   = 22'h040000,
		S_WR_INV   = 22'h080000,
		S_WR_EMIT  = 22'h100000,
		S_FAIL     = 22'h200000
	} state_t;

	state_t state_q, state_d;

	assign req_ready = (state_q == S_IDLE);

	// next state and datapath command
	always_comb begin
		state_d = state_q;
		cmd     = '{op: OP_NONE, reason: ST_OK, victim_scan: 1'b0};
		unique case (state_q)
			S_CLEAR: begin
				cmd.op = OP_CLEAR;
				if (st.clear_done) state_d = S_IDLE;
			end
			S_IDLE: begin
				if (req_valid) begin
					cmd.op = OP_ACCEPT;
					if (st.in_range_err) state_d = S_RANGE;
					else if (st.in_write) state_d = S_WR_START;
					else state_d = S_RD_EMIT;
				end
			end
			S_RANGE: begin
				if (st.slot_free) begin
					cmd.op  = OP_EMIT_RANGE;
					state_d = S_IDLE;
				end
			end
			S_RD_EMIT: begin
				if (st.slot_free) begin
					cmd.op  = OP_EMIT_READ;
					state_d = S_IDLE;
				end
			end
			S_WR_START: state_d = st.full_trig ? S_GC_CHECK : S_AL_START;
			S_GC_CHECK: begin
				if (st.gc_done) begin
					cmd.op  = OP_GC_STOP;
					state_d = S_AL_START;
				end else if (st.n_limit) begin
					cmd.op     = OP_GC_STOP;
					cmd.reason = ST_GC_LIMIT;
					state_d    = S_AL_START;
				end else begin
					cmd.op          = OP_SCAN_START;
					cmd.victim_scan = 1'b1;
					state_d         = S_VS;
				end
			end
			S_VS: begin
				if (st.scan_done) state_d = S_VS_END;
				else cmd.op = OP_SCAN_STEP;
			end
			S_VS_END: begin
				if (!st.found || st.best_zero) begin
					cmd.op     = OP_GC_STOP;
					cmd.reason = ST_NO_VICTIM;
					state_d    = S_AL_START;
				end else begin
					cmd.op  = OP_VICTIM_READ;
					state_d = S_V_LOAD;
				end
			end
			S_V_LOAD: begin
				cmd.op  = OP_VICTIM_LOAD;
				state_d = S_CP_TEST;
			end
			S_CP_TEST: begin
				if (st.i_done) state_d = S_ER;
				else if (st.cur_inv) cmd.op = OP_CP_SKIP;
				else begin
					cmd.op  = OP_CP_REV_READ;
					state_d = S_CP_REV;
				end
			end
			S_CP_REV: begin
				cmd.op  = OP_CP_FWD_READ;
				state_d = S_CP_FWD;
			end
			S_CP_FWD: begin
				if (!st.map_ok) begin
					cmd.op  = OP_CP_SKIP;
					state_d = S_CP_TEST;
				end else if (st.n_limit) begin
					cmd.op     = OP_GC_STOP;
					cmd.reason = ST_GC_LIMIT;
					state_d    = S_AL_START;
				end else begin
					cmd.op  = OP_ALLOC_COPY;
					state_d = S_AL_START;
				end
			end
			S_AL_START: begin
				if (!st.need_block) begin
					cmd.op  = OP_WP_INC;
					state_d = S_AL_DONE;
				end else if (st.free_zero) begin
					state_d = S_FAIL;
				end else begin
					cmd.op  = OP_SCAN_START;
					state_d = S_FS;
				end
			end
			S_FS: begin
				if (st.scan_done) state_d = S_FS_END;
				else cmd.op = OP_SCAN_STEP;
			end
			S_FS_END: begin
				if (!st.found) state_d = S_FAIL;
				else begin
					cmd.op  = OP_TAKE_BLOCK;
					state_d = S_AL_DONE;
				end
			end
			S_AL_DONE: begin
				if (st.ctx_copy) state_d = S_CP_EMIT;
				else begin
					cmd.op  = OP_DST_READ;
					state_d = S_WR_FWD;
				end
			end
			S_CP_EMIT: begin
				if (st.slot_free) begin
					cmd.op  = OP_CP_EMIT;
					state_d = S_CP_TEST;
				end
			end
			S_ER: begin
				if (st.n_limit) begin
					cmd.op     = OP_GC_STOP;
					cmd.reason = ST_GC_LIMIT;
					state_d    = S_AL_START;
				end else if (st.slot_free) begin
					cmd.op  = OP_ERASE;
					state_d = S_GC_CHECK;
				end
			end
			S_WR_FWD: begin
				if (st.fwd_valid) begin
					cmd.op  = OP_OLD_READ;
					state_d = S_WR_INV;
				end else state_d = S_WR_EMIT;
			end
			S_WR_INV: begin
				cmd.op  = OP_OLD_INV;
				state_d = S_WR_EMIT;
			end
			S_WR_EMIT: begin
				if (st.slot_free) begin
					cmd.op  = OP_WR_EMIT;
					state_d = S_IDLE;
				end
			end
			S_FAIL: begin
				if (st.slot_free) begin
					cmd.op  = OP_EMIT_FAIL;
					state_d = S_IDLE;
				end
			end
			default: state_d = S_IDLE;
		endcase
	end

	// state register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) state_q <= S_CLEAR;
		else state_q <= state_d;
	end

	// no copy or erase is issued once the per-request limit is reached
	a_limit: assert property (@(posedge clk) disable iff (!arst_n)
		(cmd.op == OP_CP_EMIT || cmd.op == OP_ERASE) |-> !st.n_limit)
		else $error("command issued past result limit");

endmodule

// ----- hdl/page_mapping_ftl_top.sv -----
// ----------------------------------------------------------------------------
// page_mapping_ftl_top
// Sector-mapped flash translation layer with greedy garbage collection.
// ----------------------------------------------------------------------------
// Usage: requests (read or write of one logical sector) arrive on req; each
// read gives one translation on res, each write gives zero or more copy and
// erase commands followed by its translation, which carries last = 1.
// The user writes registers through cfg_we / cfg_index / cfg_data only while
// idle; the block does not enforce it. After reset a clearing pass over the
// forward map entries empties the forward map and the block table; req.ready
// stays low during it, configuration writes still land. A read result is
// registered once the output slot is free, as the controller returns to idle
// for the next request. A write inside the open block takes an extra step to
// invalidate the old sector when the sector was mapped before. Opening a new
// block adds a walk of the block table for the free block. Each collection
// pass adds mostly the walk for the victim, plus steps per copied sector (and
// any block opening it needs), per invalid sector and per stale one. The block
// table walks go one entry per cycle through its single read port.
// One request is handled at a time. Results go through a single output
// register; while res is stalled the block holds the next result and waits.
// ----------------------------------------------------------------------------
module page_mapping_ftl_top import pmftl_pkg::*; (
	input  logic                  clk,
	input  logic                  arst_n,
	pmftl_req_if.sink             req,
	pmftl_res_if.source           res,
	input  logic                  cfg_we,
	input  logic [CFG_IDX_W-1:0]  cfg_index,
	input  logic [CFG_DATA_W-1:0] cfg_data
);

	cmd_t    cmd;
	status_t st;
	res_t    res_d;
	logic    ready;
	logic    res_valid;

	// sequencing
	pmftl_ctrl u_ctrl (
		.clk       (clk),
		.arst_n    (arst_n),
		.req_valid (req.valid),
		.req_ready (ready),
		.st        (st),
		.cmd       (cmd)
	);

	// storage and arithmetic
	pmftl_dp u_dp (
		.clk       (clk),
		.arst_n    (arst_n),
		.cmd       (cmd),
		.st        (st),
		.req_kind  (req.kind),
		.req_lsn   (req.logical_sector),
		.cfg_we    (cfg_we),
		.cfg_index (cfg_index),
		.cfg_data  (cfg_data),
		.res_ready (res.ready),
		.res_valid (res_valid),
		.res_d     (res_d)
	);

	// channel wiring
	assign req.ready             = ready;
	assign res.valid             = res_valid;
	assign res.result_kind       = res_d.result_kind;
	assign res.physical_sector   = res_d.physical_sector;
	assign res.source_sector     = res_d.source_sector;
	assign res.erase_block_index = res_d.erase_block_index;
	assign res.mapped            = res_d.mapped;
	assign res.status            = res_d.status;
	assign res.last              = res_d.last;

endmodule

// ----- test/testbench.sv -----
// ----------------------------------------------------------------------------
// testbench
// Self-checking bench for the page-mapping translation layer: a clocked
// driver sends read and write requests from a pending queue, an internal
// model of the mapping tables predicts every translation, copy and erase,
// and a clocked monitor compares each result transfer in order. Phases
// move the registers through their extremes between idle points.
// ----------------------------------------------------------------------------
module testbench;
	timeunit 1ns;
	timeprecision 1ps;
	import pmftl_pkg::*;

	localparam int CYCLE_LIMIT = 3000000;
	localparam int HOLD_CYCLES = 400;

	typedef struct {
		logic            kind;
		logic [LS_W-1:0] lsn;
	} request_t;

	logic clk;
	logic arst_n;
	logic cfg_we;
	logic [CFG_IDX_W-1:0]  cfg_index;
	logic [CFG_DATA_W-1:0] cfg_data;

	pmftl_req_if req ();
	pmftl_res_if res ();

	page_mapping_ftl_top dut (
		.clk       (clk),
		.arst_n    (arst_n),
		.req       (req.sink),
		.res       (res.source),
		.cfg_we    (cfg_we),
		.cfg_index (cfg_index),
		.cfg_data  (cfg_data)
	);

	request_t pending_requests[$];
	res_t     expected_results[$];
	int       fail_count;
	int       cycle_count;
	bit       no_idle;
	bit       hold_go;
	int       hold_count;

	// shadow registers
	int cfg_wear;
	int cfg_thr;
	int cfg_extra;
	int cfg_lsecs;

	// shadow mapping tables
	int map_fwd[LOGICAL_SPACE];
	bit map_fwd_ok[LOGICAL_SPACE];
	int map_rev[PHYS_SECTORS];
	bit [BLOCK_SECTORS-1:0] blk_inv[BLOCK_COUNT];
	int blk_inv_cnt[BLOCK_COUNT];
	int blk_erase[BLOCK_COUNT];
	bit blk_free[BLOCK_COUNT];
	int free_total;
	int wr_ptr;
	bit wr_open;

	// clock and cycle limit
	initial begin
		clk = 1'b0;
		forever #6 clk = ~clk;
	end

	always @(posedge clk) begin
		cycle_count <= cycle_count + 1;
		if (cycle_count > CYCLE_LIMIT) begin
			$display("** page_mapping_ftl_top: FAILED **");
			$finish;
		end
	end

	function automatic void push_result(logic [1:0] kind, int phys, int src, int blk,
		bit mapped, logic [2:0] status, bit last);
		res_t r;
		r.result_kind       = kind;
		r.physical_sector   = phys[PS_W-1:0];
		r.source_sector     = src[PS_W-1:0];
		r.erase_block_index = blk[BLK_W-1:0];
		r.mapped            = mapped;
		r.status            = status;
		r.last              = last;
		expected_results.insert(expected_results.size(), r);
	endfunction

	function automatic bit open_full();
		return wr_open && (wr_ptr % BLOCK_SECTORS) == BLOCK_SECTORS - 1;
	endfunction

	function automatic bit take_block(output int blk);
		bit found;
		int best;
		found = 0;
		best = 0;
		for (int i = 0; i < BLOCK_COUNT; i++) begin
			if (!blk_free[i])
				continue;
			if (!found || (cfg_wear != 0 && blk_erase[i] < blk_erase[best])) begin
				best = i;
				found = 1;
				if (cfg_wear == 0)
					break;
			end
		end
		blk = best;
		if (!found)
			return 0;
		blk_free[best] = 0;
		if (free_total > 0)
			free_total--;
		return 1;
	endfunction

	function automatic bit alloc_sector(output int dst);
		int b;
		dst = 0;
		if (!wr_open || open_full()) begin
			if (free_total == 0 || !take_block(b))
				return 0;
			wr_ptr = b * BLOCK_SECTORS;
			wr_open = 1;
		end else begin
			wr_ptr++;
		end
		dst = wr_ptr;
		return 1;
	endfunction

	// greedy victim: most invalid sectors, open block skipped while filling
	function automatic bit find_victim(output int victim);
		bit skip;
		int open_blk;
		int best;
		int best_cnt;
		bit found;
		skip = wr_open && !open_full();
		open_blk = wr_open ? wr_ptr / BLOCK_SECTORS : 0;
		best = 0;
		best_cnt = 0;
		found = 0;
		for (int i = 0; i < BLOCK_COUNT; i++) begin
			if (skip && i == open_blk)
				continue;
			if (!found || blk_inv_cnt[i] > best_cnt) begin
				best = i;
				best_cnt = blk_inv_cnt[i];
				found = 1;
				if (best_cnt == BLOCK_SECTORS)
					break;
			end
		end
		victim = best;
		return found && best_cnt != 0;
	endfunction

	function automatic logic [2:0] run_collection(inout int n);
		int target;
		int v;
		int src;
		int lsn;
		int dst;
		target = cfg_thr + cfg_extra;
		while (free_total < target) begin
			if (n >= MAX_RESULTS - 1)
				return ST_GC_LIMIT;
			if (!find_victim(v))
				return ST_NO_VICTIM;
			for (int i = 0; i < BLOCK_SECTORS; i++) begin
				if (blk_inv[v][i])
					continue;
				src = v * BLOCK_SECTORS + i;
				lsn = map_rev[src] % LOGICAL_SPACE;
				// stale reverse entries count as invalid
				if (!map_fwd_ok[lsn] || map_fwd[lsn] != src)
					continue;
				if (n >= MAX_RESULTS - 1)
					return ST_GC_LIMIT;
				if (!alloc_sector(dst))
					return ST_NO_FREE;
				push_result(RK_COPY, dst, src, 0, 0, ST_OK, 0);
				n++;
				map_fwd[lsn] = dst;
				map_rev[dst] = lsn;
				blk_inv[v][i] = 1;
				blk_inv_cnt[v]++;
			end
			if (n >= MAX_RESULTS - 1)
				return ST_GC_LIMIT;
			blk_inv[v] = '0;
			blk_inv_cnt[v] = 0;
			blk_erase[v]++;
			blk_free[v] = 1;
			free_total++;
			push_result(RK_ERASE, 0, 0, v, 0, ST_OK, 0);
			n++;
		end
		return ST_OK;
	endfunction

	// expected results of one accepted request
	function automatic void predict_request(logic kind, int lsn);
		logic [2:0] reason;
		int n;
		int dst;
		int old;
		int b;
		int s;
		reason = ST_OK;
		n = 0;
		if (lsn >= cfg_lsecs) begin
			push_result(RK_XLATE, 0, 0, 0, 0, ST_RANGE, 1);
			return;
		end
		if (kind == KIND_READ) begin
			if (map_fwd_ok[lsn])
				push_result(RK_XLATE, map_fwd[lsn], 0, 0, 1, ST_OK, 1);
			else
				push_result(RK_XLATE, 0, 0, 0, 0, ST_OK, 1);
			return;
		end
		if (open_full() && free_total < cfg_thr)
			reason = run_collection(n);
		if (!alloc_sector(dst)) begin
			push_result(RK_XLATE, 0, 0, 0, 0, ST_NO_FREE, 1);
			return;
		end
		if (map_fwd_ok[lsn]) begin
			old = map_fwd[lsn];
			b = (old / BLOCK_SECTORS) % BLOCK_COUNT;
			s = old % BLOCK_SECTORS;
			if (!blk_inv[b][s]) begin
				blk_inv[b][s] = 1;
				blk_inv_cnt[b]++;
			end
		end
		map_fwd[lsn] = dst;
		map_fwd_ok[lsn] = 1;
		map_rev[dst % PHYS_SECTORS] = lsn;
		push_result(RK_XLATE, dst, 0, 0, 1, reason, 1);
	endfunction

	// request driver
	always @(posedge clk or negedge arst_n) begin
		request_t item;
		if (!arst_n) begin
			req.valid <= 1'b0;
			req.kind <= KIND_READ;
			req.logical_sector <= '0;
		end else begin
			if (req.valid && req.ready)
				predict_request(req.kind, req.logical_sector);
			if (req.valid && !req.ready) begin
				// hold the offered transfer
			end else if (pending_requests.size() > 0 &&
				(no_idle || $urandom_range(99) >= 16)) begin
				item = pending_requests.pop_front();
				req.valid <= 1'b1;
				req.kind <= item.kind;
				req.logical_sector <= item.lsn;
			end else begin
				req.valid <= 1'b0;
			end
		end
	end

	// result ready, with one long hold-off
	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			res.ready <= 1'b0;
			hold_count <= 0;
		end else if (hold_go && hold_count < HOLD_CYCLES) begin
			hold_count <= hold_count + 1;
			res.ready <= 1'b0;
		end else begin
			res.ready <= no_idle || $urandom_range(99) >= 16;
		end
	end

	// result monitor
	always @(posedge clk) begin
		res_t got;
		res_t want;
		if (arst_n && res.valid && res.ready) begin
			got.result_kind       = res.result_kind;
			got.physical_sector   = res.physical_sector;
			got.source_sector     = res.source_sector;
			got.erase_block_index = res.erase_block_index;
			got.mapped            = res.mapped;
			got.status            = res.status;
			got.last              = res.last;
			if (expected_results.size() == 0) begin
				$display("%t: unexpected result transfer, expected none, actual %p",
					$realtime, got);
				fail_count++;
			end else begin
				want = expected_results.pop_front();
				if (got !== want) begin
					$display("%t: result mismatch, expected %p, actual %p",
						$realtime, want, got);
					fail_count++;
				end
			end
		end
	end

	task automatic write_reg(logic [CFG_IDX_W-1:0] idx, int value);
		@(posedge clk);
		cfg_we <= 1'b1;
		cfg_index <= idx;
		cfg_data <= value[CFG_DATA_W-1:0];
		@(posedge clk);
		cfg_we <= 1'b0;
		case (idx)
			CFG_WEAR_MODE: cfg_wear = value & 1;
			CFG_GC_THR:    cfg_thr = value & 'h7f;
			CFG_GC_EXTRA:  cfg_extra = value & 'h7f;
			default:       cfg_lsecs = value & 'h3ff;
		endcase
	endtask

	task automatic set_regs(int wear, int thr, int extra, int lsecs);
		write_reg(CFG_WEAR_MODE, wear);
		write_reg(CFG_GC_THR, thr);
		write_reg(CFG_GC_EXTRA, extra);
		write_reg(CFG_LOG_SECS, lsecs);
	endtask

	task automatic add_request(logic kind, int lsn);
		request_t item;
		item.kind = kind;
		item.lsn = lsn[LS_W-1:0];
		pending_requests.insert(pending_requests.size(), item);
	endtask

	task automatic add_random(int count, int write_pct, int lsn_max);
		for (int i = 0; i < count; i++)
			add_request($urandom_range(99) < write_pct ? KIND_WRITE : KIND_READ,
				$urandom_range(lsn_max));
	endtask

	// wait until every transfer is out and the block has gone idle
	task automatic drain();
		while (pending_requests.size() != 0 || req.valid || expected_results.size() != 0)
			@(posedge clk);
		repeat (300) @(posedge clk);
	endtask

	// stimulus phases
	initial begin
		arst_n = 1'b0;
		cfg_we = 1'b0;
		cfg_index = '0;
		cfg_data = '0;
		req.valid = 1'b0;
		req.kind = KIND_READ;
		req.logical_sector = '0;
		res.ready = 1'b0;
		fail_count = 0;
		cycle_count = 0;
		no_idle = 0;
		hold_go = 0;
		cfg_wear = RST_WEAR_MODE;
		cfg_thr = RST_GC_THR;
		cfg_extra = RST_GC_EXTRA;
		cfg_lsecs = RST_LOG_SECS;
		for (int i = 0; i < LOGICAL_SPACE; i++) begin
			map_fwd[i] = 0;
			map_fwd_ok[i] = 0;
		end
		for (int i = 0; i < PHYS_SECTORS; i++)
			map_rev[i] = 0;
		for (int i = 0; i < BLOCK_COUNT; i++) begin
			blk_inv[i] = '0;
			blk_inv_cnt[i] = 0;
			blk_erase[i] = 0;
			blk_free[i] = 1;
		end
		free_total = BLOCK_COUNT;
		wr_ptr = 0;
		wr_open = 0;
		repeat (12) @(posedge clk);
		arst_n <= 1'b1;

		// directed: unmapped read, remap, range edges at reset settings
		add_request(KIND_READ, 0);
		add_request(KIND_WRITE, 0);
		add_request(KIND_READ, 0);
		add_request(KIND_WRITE, 0);
		add_request(KIND_READ, 0);
		add_request(KIND_READ, 447);
		add_request(KIND_WRITE, 447);
		add_request(KIND_READ, 447);
		add_request(KIND_READ, 448);
		add_request(KIND_WRITE, 448);
		add_request(KIND_WRITE, 511);
		add_request(KIND_READ, 511);
		add_request(KIND_WRITE, 255);
		add_request(KIND_WRITE, 256);
		add_request(KIND_READ, 256);
		add_request(KIND_WRITE, 170);
		add_request(KIND_WRITE, 85);
		add_request(KIND_READ, 85);
		drain();

		// early collection, first free block, results stalled by a long hold-off
		set_regs(0, 62, 1, 512);
		hold_go = 1;
		add_random(40, 75, 31);
		drain();

		// collection never reaches its target: no victim and limit cases
		set_regs(1, 64, 64, 40);
		no_idle = 1;
		add_random(30, 80, 63);
		drain();
		no_idle = 0;

		// no collection at all
		set_regs(0, 0, 0, 512);
		add_random(16, 100, 511);
		add_random(4, 0, 511);
		drain();

		// collection started by a full threshold
		set_regs(1, 64, 0, 512);
		add_random(6, 70, 511);
		drain();

		// everything out of range
		set_regs(0, 1, 0, 0);
		add_random(6, 50, 511);
		drain();

		if (fail_count == 0)
			$display("** page_mapping_ftl_top: PASSED **");
		else
			$display("** page_mapping_ftl_top: FAILED **");
		$finish;
	end

endmodule
